>>> design/time_window_task_table_assert.svh
`ifndef TIME_WINDOW_TASK_TABLE_ASSERT_SVH
`define TIME_WINDOW_TASK_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twt assertion failed");

// next-cycle implication, checked out of reset
`define TWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twt assertion failed");

`endif

>>> design/twt_pkg.sv
package twt_pkg;

  localparam int TASK_SLOTS    = 16;
  localparam int CHANNEL_COUNT = 6;
  localparam int SLOT_IW       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int SLOT_W     = 5;
  localparam int PARAM_W    = 4;
  localparam int VALUE_W    = 8;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int FEAT_W     = 3;
  localparam int NOW_W      = 17;
  localparam int HMS_W      = HOUR_W + MIN_W + SEC_W;
  localparam int TOTAL_W    = 17;
  localparam int MATCH_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int HOUR_LIMIT   = 23;
  localparam int MINSEC_LIMIT = 59;

  localparam logic [TOTAL_W-1:0] SECS_PER_HOUR = TOTAL_W'(3600);
  localparam logic [TOTAL_W-1:0] SECS_PER_MIN  = TOTAL_W'(60);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SET    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NO_ENTRY = 2'd2,
    STAT_BAD      = 2'd3
  } status_e;

  typedef enum logic [PARAM_W-1:0] {
    PRM_START_H = 4'd0,
    PRM_START_M = 4'd1,
    PRM_START_S = 4'd2,
    PRM_STOP_H  = 4'd3,
    PRM_STOP_M  = 4'd4,
    PRM_STOP_S  = 4'd5,
    PRM_ACT_H   = 4'd6,
    PRM_ACT_M   = 4'd7,
    PRM_ACT_S   = 4'd8,
    PRM_MOTION  = 4'd9,
    PRM_AUDIO   = 4'd10,
    PRM_ACTUATE = 4'd11,
    PRM_CHANNEL = 4'd12,
    PRM_PROGRAM = 4'd13
  } param_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACT_HOUR = 2'd0,
    CFG_ACT_MIN  = 2'd1,
    CFG_ACT_SEC  = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    PART_HOUR = 2'd0,
    PART_MIN  = 2'd1,
    PART_SEC  = 2'd2
  } hms_part_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ENTRY,
    ST_CALC_START,
    ST_CALC_STOP,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_WINDOW,
    ALU_TOTAL
  } alu_op_e;

  typedef struct packed {
    logic                     used_we;
    logic                     used_val;
    logic                     start_we;
    logic                     stop_we;
    logic                     active_we;
    logic                     feat_we;
    logic                     prog_we;
    logic                     chan_we;
    logic                     tstart_we;
    logic                     tstop_we;
    logic [HMS_W-1:0]         start_hms;
    logic [HMS_W-1:0]         stop_hms;
    logic [HMS_W-1:0]         active_hms;
    logic [FEAT_W-1:0]        feat;
    logic [VALUE_W-1:0]       prog;
    logic [CHANNEL_COUNT-1:0] chan;
    logic [TOTAL_W-1:0]       total;
  } tbl_wr_t;

  typedef struct packed {
    logic                     used;
    logic [HMS_W-1:0]         start_hms;
    logic [HMS_W-1:0]         stop_hms;
    logic [HMS_W-1:0]         active_hms;
    logic [TOTAL_W-1:0]       start_tot;
    logic [TOTAL_W-1:0]       stop_tot;
    logic [FEAT_W-1:0]        feat;
    logic [CHANNEL_COUNT-1:0] chan;
  } tbl_rd_t;

  function automatic logic [HMS_W-1:0] pack_hms(input logic [HOUR_W-1:0] h,
                                                input logic [MIN_W-1:0]  m,
                                                input logic [SEC_W-1:0]  s);
    return {h, m, s};
  endfunction

  function automatic logic time_ok(input logic [HOUR_W-1:0] h,
                                   input logic [MIN_W-1:0]  m,
                                   input logic [SEC_W-1:0]  s);
    return (h <= HOUR_W'(HOUR_LIMIT)) && (m <= MIN_W'(MINSEC_LIMIT)) &&
           (s <= SEC_W'(MINSEC_LIMIT));
  endfunction

  function automatic hms_part_e param_part(input param_e p);
    hms_part_e r;
    case (p)
      PRM_START_H, PRM_STOP_H, PRM_ACT_H: r = PART_HOUR;
      PRM_START_M, PRM_STOP_M, PRM_ACT_M: r = PART_MIN;
      default:                            r = PART_SEC;
    endcase
    return r;
  endfunction

  function automatic logic [HMS_W-1:0] replace_part(input logic [HMS_W-1:0]   t,
                                                    input hms_part_e          part,
                                                    input logic [VALUE_W-1:0] v);
    logic [HMS_W-1:0] r;
    case (part)
      PART_HOUR: r = {v[HOUR_W-1:0], t[MIN_W+SEC_W-1:0]};
      PART_MIN:  r = {t[HMS_W-1:MIN_W+SEC_W], v[MIN_W-1:0], t[SEC_W-1:0]};
      default:   r = {t[HMS_W-1:SEC_W], v[SEC_W-1:0]};
    endcase
    return r;
  endfunction

endpackage

>>> design/twt_alu.sv
module twt_alu (
  input  twt_pkg::alu_op_e                  op_i,
  input  logic [twt_pkg::HMS_W-1:0]         hms_i,
  input  logic [twt_pkg::NOW_W-1:0]         now_i,
  input  logic [twt_pkg::TOTAL_W-1:0]       lo_i,
  input  logic [twt_pkg::TOTAL_W-1:0]       hi_i,
  output logic [twt_pkg::TOTAL_W-1:0]       total_o,
  output logic                              hit_o
);
  import twt_pkg::*;

  logic [TOTAL_W-1:0] hour_term;
  logic [TOTAL_W-1:0] min_term;
  logic [TOTAL_W-1:0] sec_term;
  logic               in_window;

  // constant multiplies reduce to a few shifted adds
  assign hour_term = TOTAL_W'(hms_i[HMS_W-1:MIN_W+SEC_W]) * SECS_PER_HOUR;
  assign min_term  = TOTAL_W'(hms_i[MIN_W+SEC_W-1:SEC_W]) * SECS_PER_MIN;
  assign sec_term  = TOTAL_W'(hms_i[SEC_W-1:0]);

  // open interval: both bounds excluded
  assign in_window = (now_i > lo_i) && (now_i < hi_i);

  assign total_o = (op_i == ALU_TOTAL) ? hour_term + min_term + sec_term : '0;
  assign hit_o   = (op_i == ALU_WINDOW) && in_window;

endmodule

>>> design/twt_table.sv
module twt_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [twt_pkg::SLOT_IW-1:0]   idx_i,
  input  twt_pkg::tbl_wr_t              wr_i,
  output twt_pkg::tbl_rd_t              rd_o
);
  import twt_pkg::*;

  logic                     used_q   [TASK_SLOTS];
  logic [FEAT_W-1:0]        feat_q   [TASK_SLOTS];
  logic [CHANNEL_COUNT-1:0] chan_q   [TASK_SLOTS];
  logic [HMS_W-1:0]         start_q  [TASK_SLOTS];
  logic [HMS_W-1:0]         stop_q   [TASK_SLOTS];
  logic [HMS_W-1:0]         active_q [TASK_SLOTS];
  logic [TOTAL_W-1:0]       tstart_q [TASK_SLOTS];
  logic [TOTAL_W-1:0]       tstop_q  [TASK_SLOTS];
  logic [VALUE_W-1:0]       prog_q   [TASK_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        used_q[i] <= 1'b0;
        feat_q[i] <= '0;
        chan_q[i] <= '0;
      end
    end else begin
      if (wr_i.used_we) used_q[idx_i] <= wr_i.used_val;
      if (wr_i.feat_we) feat_q[idx_i] <= wr_i.feat;
      if (wr_i.chan_we) chan_q[idx_i] <= wr_i.chan;
    end
  end

  // time fields and program only matter once an add has written them
  always_ff @(posedge clk_i) begin
    if (wr_i.start_we)  start_q[idx_i]  <= wr_i.start_hms;
    if (wr_i.stop_we)   stop_q[idx_i]   <= wr_i.stop_hms;
    if (wr_i.active_we) active_q[idx_i] <= wr_i.active_hms;
    if (wr_i.tstart_we) tstart_q[idx_i] <= wr_i.total;
    if (wr_i.tstop_we)  tstop_q[idx_i]  <= wr_i.total;
    if (wr_i.prog_we)   prog_q[idx_i]   <= wr_i.prog;
  end

  assign rd_o.used       = used_q[idx_i];
  assign rd_o.start_hms  = start_q[idx_i];
  assign rd_o.stop_hms   = stop_q[idx_i];
  assign rd_o.active_hms = active_q[idx_i];
  assign rd_o.start_tot  = tstart_q[idx_i];
  assign rd_o.stop_tot   = tstop_q[idx_i];
  assign rd_o.feat       = feat_q[idx_i];
  assign rd_o.chan       = chan_q[idx_i];

endmodule

>>> design/time_window_task_table.sv
// Daily schedule table with 16 entries, driven one command item at a time.
// Input channel: in_valid_i / in_stall_o with cmd, slot, param, value, the add
// start and stop times, feature flags and now_seconds, each on its own port.
// Output channel: out_valid_o / out_stall_i with status, assigned_slot,
// match_found and match_index; one result item per input item.
// Config: cfg_we_i writes cfg_wdata_i into the default active hour, minute or
// second register picked by cfg_index_i; write only while the block is idle.
// Steps: a bad add time or a slot number out of range goes from decode straight
// to the result; remove and set read the entry, and a set of a time field then
// rebuilds the start and stop totals; add scans from slot 0 to the first free
// slot and rebuilds its totals, and search scans to the first match.
// The entry scan walks one slot per cycle through a single window compare /
// time-to-seconds unit; the next item can be taken in the cycle after the
// result is registered.
// A finished result sits in the output register; a stalled receiver does not
// block acceptance of the next item, but that item waits in its final step
// until the output register frees up.
// Reset empties the table, clears feature and channel flags and sets the
// default active time to 00:00:00.
`include "time_window_task_table_assert.svh"

module time_window_task_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [twt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [twt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      cmd_i,
  input  logic [twt_pkg::SLOT_W-1:0]      slot_i,
  input  logic [twt_pkg::PARAM_W-1:0]     param_i,
  input  logic [twt_pkg::VALUE_W-1:0]     value_i,
  input  logic [twt_pkg::HOUR_W-1:0]      start_hour_i,
  input  logic [twt_pkg::MIN_W-1:0]       start_minute_i,
  input  logic [twt_pkg::SEC_W-1:0]       start_second_i,
  input  logic [twt_pkg::HOUR_W-1:0]      stop_hour_i,
  input  logic [twt_pkg::MIN_W-1:0]       stop_minute_i,
  input  logic [twt_pkg::SEC_W-1:0]       stop_second_i,
  input  logic [twt_pkg::FEAT_W-1:0]      feature_flags_i,
  input  logic [twt_pkg::NOW_W-1:0]       now_seconds_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [twt_pkg::SLOT_W-1:0]      assigned_slot_o,
  output logic                            match_found_o,
  output logic [twt_pkg::MATCH_W-1:0]     match_index_o
);
  import twt_pkg::*;

  state_e state_q, state_d;

  logic [HOUR_W-1:0] def_hour_q;
  logic [MIN_W-1:0]  def_min_q;
  logic [SEC_W-1:0]  def_sec_q;

  cmd_e              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [PARAM_W-1:0] param_q;
  logic [VALUE_W-1:0] value_q;
  logic [HOUR_W-1:0] sh_q, eh_q;
  logic [MIN_W-1:0]  sm_q, em_q;
  logic [SEC_W-1:0]  ss_q, es_q;
  logic [FEAT_W-1:0] flags_q;
  logic [NOW_W-1:0]  now_q;

  logic [SLOT_IW-1:0] idx_q, idx_d;

  status_e            res_status_q, res_status_d;
  logic [SLOT_W-1:0]  res_assigned_q, res_assigned_d;
  logic               res_found_q, res_found_d;
  logic [MATCH_W-1:0] res_index_q, res_index_d;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [SLOT_W-1:0]  out_assigned_q;
  logic               out_found_q;
  logic [MATCH_W-1:0] out_index_q;
  logic               out_load;
  logic               out_free;

  tbl_wr_t            wr;
  tbl_rd_t            rd;
  alu_op_e            alu_op;
  logic [HMS_W-1:0]   alu_hms;
  logic [TOTAL_W-1:0] alu_total;
  logic               alu_hit;

  logic               in_acc;
  logic               add_bad;
  logic               slot_bad;
  logic               scan_last;
  logic               scan_hit;
  hms_part_e          prm_part;
  logic               prm_is_time;
  logic               val_ok;
  logic               chan_ok;
  logic [CHANNEL_COUNT-1:0] chan_flip;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign add_bad   = !time_ok(sh_q, sm_q, ss_q) || !time_ok(eh_q, em_q, es_q);
  assign slot_bad  = (slot_q == '0) || (slot_q > SLOT_W'(TASK_SLOTS));
  assign scan_last = (idx_q == SLOT_IW'(TASK_SLOTS - 1));
  assign scan_hit  = rd.used && alu_hit;

  assign prm_part    = param_part(param_e'(param_q));
  assign prm_is_time = param_q inside {[PRM_START_H:PRM_ACT_S]};
  assign val_ok      = (prm_part == PART_HOUR) ? (value_q <= VALUE_W'(HOUR_LIMIT))
                                               : (value_q <= VALUE_W'(MINSEC_LIMIT));
  assign chan_ok     = (value_q != '0) && (value_q <= VALUE_W'(CHANNEL_COUNT));

  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      chan_flip[c] = (value_q == VALUE_W'(c + 1));
    end
  end

  twt_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx_q),
    .wr_i   (wr),
    .rd_o   (rd)
  );

  twt_alu u_alu (
    .op_i    (alu_op),
    .hms_i   (alu_hms),
    .now_i   (now_q),
    .lo_i    (rd.start_tot),
    .hi_i    (rd.stop_tot),
    .total_o (alu_total),
    .hit_o   (alu_hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (cmd_q)
          CMD_ADD:    state_d = add_bad ? ST_DONE : ST_SCAN;
          CMD_SEARCH: state_d = ST_SCAN;
          default:    state_d = slot_bad ? ST_DONE : ST_ENTRY;
        endcase
      end
      ST_SCAN: begin
        if (cmd_q == CMD_ADD) begin
          if (!rd.used)      state_d = ST_CALC_START;
          else if (scan_last) state_d = ST_DONE;
        end else begin
          if (scan_hit || scan_last) state_d = ST_DONE;
        end
      end
      ST_ENTRY: begin
        if (rd.used && cmd_q == CMD_SET && prm_is_time && val_ok) begin
          state_d = ST_CALC_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CALC_START: state_d = ST_CALC_STOP;
      ST_CALC_STOP:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d          = idx_q;
    res_status_d   = res_status_q;
    res_assigned_d = res_assigned_q;
    res_found_d    = res_found_q;
    res_index_d    = res_index_q;
    wr             = '0;
    alu_op         = ALU_WINDOW;
    alu_hms        = rd.start_hms;
    out_load       = 1'b0;
    case (state_q)
      ST_DECODE: begin
        idx_d          = '0;
        res_status_d   = STAT_OK;
        res_assigned_d = '0;
        res_found_d    = 1'b0;
        res_index_d    = '0;
        case (cmd_q)
          CMD_ADD: begin
            if (add_bad) res_status_d = STAT_BAD;
          end
          CMD_SEARCH: ;
          default: begin
            idx_d = SLOT_IW'(slot_q - SLOT_W'(1));
            if (slot_bad) res_status_d = STAT_NO_ENTRY;
          end
        endcase
      end
      ST_SCAN: begin
        if (cmd_q == CMD_ADD) begin
          if (!rd.used) begin
            wr.used_we     = 1'b1;
            wr.used_val    = 1'b1;
            wr.start_we    = 1'b1;
            wr.stop_we     = 1'b1;
            wr.active_we   = 1'b1;
            wr.feat_we     = 1'b1;
            wr.prog_we     = 1'b1;
            wr.start_hms   = pack_hms(sh_q, sm_q, ss_q);
            wr.stop_hms    = pack_hms(eh_q, em_q, es_q);
            wr.active_hms  = pack_hms(def_hour_q, def_min_q, def_sec_q);
            wr.feat        = flags_q;
            wr.prog        = value_q;
            res_assigned_d = SLOT_W'(idx_q) + SLOT_W'(1);
          end else if (scan_last) begin
            res_status_d = STAT_FULL;
          end else begin
            idx_d = idx_q + SLOT_IW'(1);
          end
        end else begin
          if (scan_hit) begin
            res_found_d = 1'b1;
            res_index_d = MATCH_W'(idx_q);
          end else if (!scan_last) begin
            idx_d = idx_q + SLOT_IW'(1);
          end
        end
      end
      ST_ENTRY: begin
        if (!rd.used) begin
          res_status_d = STAT_NO_ENTRY;
        end else if (cmd_q == CMD_REMOVE) begin
          wr.used_we  = 1'b1;
          wr.used_val = 1'b0;
          wr.feat_we  = 1'b1;
          wr.feat     = '0;
        end else begin
          wr.start_hms  = replace_part(rd.start_hms, prm_part, value_q);
          wr.stop_hms   = replace_part(rd.stop_hms, prm_part, value_q);
          wr.active_hms = replace_part(rd.active_hms, prm_part, value_q);
          wr.feat       = rd.feat;
          wr.chan       = rd.chan ^ chan_flip;
          wr.prog       = value_q;
          case (param_e'(param_q))
            PRM_START_H, PRM_START_M, PRM_START_S: begin
              if (val_ok) wr.start_we = 1'b1;
              else        res_status_d = STAT_BAD;
            end
            PRM_STOP_H, PRM_STOP_M, PRM_STOP_S: begin
              if (val_ok) wr.stop_we = 1'b1;
              else        res_status_d = STAT_BAD;
            end
            PRM_ACT_H, PRM_ACT_M, PRM_ACT_S: begin
              if (val_ok) wr.active_we = 1'b1;
              else        res_status_d = STAT_BAD;
            end
            PRM_MOTION: begin
              wr.feat_we = 1'b1;
              wr.feat[0] = (value_q != '0);
            end
            PRM_AUDIO: begin
              wr.feat_we = 1'b1;
              wr.feat[1] = (value_q != '0);
            end
            PRM_ACTUATE: begin
              wr.feat_we = 1'b1;
              wr.feat[2] = (value_q != '0);
            end
            PRM_CHANNEL: begin
              if (chan_ok) wr.chan_we = 1'b1;
              else         res_status_d = STAT_BAD;
            end
            PRM_PROGRAM: wr.prog_we = 1'b1;
            default:     res_status_d = STAT_BAD;
          endcase
        end
      end
      // totals are rebuilt from the stored packed times, one per cycle
      ST_CALC_START: begin
        alu_op       = ALU_TOTAL;
        alu_hms      = rd.start_hms;
        wr.tstart_we = 1'b1;
        wr.total     = alu_total;
      end
      ST_CALC_STOP: begin
        alu_op      = ALU_TOTAL;
        alu_hms     = rd.stop_hms;
        wr.tstop_we = 1'b1;
        wr.total    = alu_total;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      def_hour_q  <= '0;
      def_min_q   <= '0;
      def_sec_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_ACT_HOUR: def_hour_q <= cfg_wdata_i[HOUR_W-1:0];
          CFG_ACT_MIN:  def_min_q  <= cfg_wdata_i[MIN_W-1:0];
          CFG_ACT_SEC:  def_sec_q  <= cfg_wdata_i[SEC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_e'(cmd_i);
      slot_q  <= slot_i;
      param_q <= param_i;
      value_q <= value_i;
      sh_q    <= start_hour_i;
      sm_q    <= start_minute_i;
      ss_q    <= start_second_i;
      eh_q    <= stop_hour_i;
      em_q    <= stop_minute_i;
      es_q    <= stop_second_i;
      flags_q <= feature_flags_i;
      now_q   <= now_seconds_i;
    end
    idx_q          <= idx_d;
    res_status_q   <= res_status_d;
    res_assigned_q <= res_assigned_d;
    res_found_q    <= res_found_d;
    res_index_q    <= res_index_d;
    if (out_load) begin
      out_status_q   <= res_status_q;
      out_assigned_q <= res_assigned_q;
      out_found_q    <= res_found_q;
      out_index_q    <= res_index_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign assigned_slot_o = out_assigned_q;
  assign match_found_o   = out_found_q;
  assign match_index_o   = out_index_q;

  `TWT_ASSERT_IMPLY(a_match_ok, clk_i, rst_ni, out_valid_o && match_found_o, status_o == STAT_OK && assigned_slot_o == '0)
  `TWT_ASSERT_IMPLY(a_assign_ok, clk_i, rst_ni, out_valid_o && assigned_slot_o != '0, status_o == STAT_OK && !match_found_o)
  `TWT_ASSERT_IMPLY(a_load_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == ST_DONE))
  `TWT_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == ST_DECODE)

endmodule

>>> tb/sv/time_window_task_table_test.sv
`timescale 1ns / 1ps

module time_window_task_table_test;
  import twt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 25;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 325;

  // param codes that the block does not define
  localparam logic [PARAM_W-1:0] PRM_SPARE_LO = 4'd14;
  localparam logic [PARAM_W-1:0] PRM_SPARE_HI = 4'd15;

  typedef logic [HMS_W-1:0]   hms_t;
  typedef logic [TOTAL_W-1:0] secs_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [PARAM_W-1:0] prm;
    logic [VALUE_W-1:0] value;
    logic [HOUR_W-1:0]  start_h;
    logic [MIN_W-1:0]   start_m;
    logic [SEC_W-1:0]   start_s;
    logic [HOUR_W-1:0]  stop_h;
    logic [MIN_W-1:0]   stop_m;
    logic [SEC_W-1:0]   stop_s;
    logic [FEAT_W-1:0]  flags;
    logic [NOW_W-1:0]   now;
  } command_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  assigned;
    logic               found;
    logic [MATCH_W-1:0] index;
  } result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            cmd_i           = '0;
  logic [SLOT_W-1:0]     slot_i          = '0;
  logic [PARAM_W-1:0]    param_i         = '0;
  logic [VALUE_W-1:0]    value_i         = '0;
  logic [HOUR_W-1:0]     start_hour_i    = '0;
  logic [MIN_W-1:0]      start_minute_i  = '0;
  logic [SEC_W-1:0]      start_second_i  = '0;
  logic [HOUR_W-1:0]     stop_hour_i     = '0;
  logic [MIN_W-1:0]      stop_minute_i   = '0;
  logic [SEC_W-1:0]      stop_second_i   = '0;
  logic [FEAT_W-1:0]     feature_flags_i = '0;
  logic [NOW_W-1:0]      now_seconds_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [1:0]            status_o;
  logic [SLOT_W-1:0]     assigned_slot_o;
  logic                  match_found_o;
  logic [MATCH_W-1:0]    match_index_o;

  time_window_task_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .slot_i          (slot_i),
    .param_i         (param_i),
    .value_i         (value_i),
    .start_hour_i    (start_hour_i),
    .start_minute_i  (start_minute_i),
    .start_second_i  (start_second_i),
    .stop_hour_i     (stop_hour_i),
    .stop_minute_i   (stop_minute_i),
    .stop_second_i   (stop_second_i),
    .feature_flags_i (feature_flags_i),
    .now_seconds_i   (now_seconds_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .assigned_slot_o (assigned_slot_o),
    .match_found_o   (match_found_o),
    .match_index_o   (match_index_o)
  );

  // schedule table as the testbench sees it
  logic                     task_used       [TASK_SLOTS] = '{default: 1'b0};
  hms_t                     task_start_hms  [TASK_SLOTS] = '{default: '0};
  hms_t                     task_stop_hms   [TASK_SLOTS] = '{default: '0};
  hms_t                     task_active_hms [TASK_SLOTS] = '{default: '0};
  secs_t                    task_start_secs [TASK_SLOTS] = '{default: '0};
  secs_t                    task_stop_secs  [TASK_SLOTS] = '{default: '0};
  logic [FEAT_W-1:0]        task_features   [TASK_SLOTS] = '{default: '0};
  logic [VALUE_W-1:0]       task_program    [TASK_SLOTS] = '{default: '0};
  logic [CHANNEL_COUNT-1:0] task_channels   [TASK_SLOTS] = '{default: '0};
  logic [HOUR_W-1:0]        default_hour   = '0;
  logic [MIN_W-1:0]         default_minute = '0;
  logic [SEC_W-1:0]         default_second = '0;

  result_t expected_results[$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      burst_left     = 0;
  int      stall_run      = 0;
  int      stall_pct      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic secs_t hms_to_seconds(input hms_t t);
    return secs_t'(t[16:12] * 3600 + t[11:6] * 60 + t[5:0]);
  endfunction

  function automatic logic hms_valid(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
                                     input logic [SEC_W-1:0] s);
    return h <= HOUR_LIMIT && m <= MINSEC_LIMIT && s <= MINSEC_LIMIT;
  endfunction

  function automatic hms_t hms_splice(input hms_t t, input hms_part_e part,
                                      input logic [VALUE_W-1:0] v);
    case (part)
      PART_HOUR: return {v[HOUR_W-1:0], t[11:0]};
      PART_MIN:  return {t[16:12], v[MIN_W-1:0], t[5:0]};
      default:   return {t[16:6], v[SEC_W-1:0]};
    endcase
  endfunction

  // applies one command to the table and returns the result it should give
  function automatic result_t predict_command(input command_t c);
    result_t   r;
    int        i;
    int        idx;
    int        limit;
    hms_part_e part;
    r = '0;
    r.status = STAT_OK;
    if (c.cmd == CMD_ADD) begin
      if (!hms_valid(c.start_h, c.start_m, c.start_s) ||
          !hms_valid(c.stop_h, c.stop_m, c.stop_s)) begin
        r.status = STAT_BAD;
      end else begin
        r.status = STAT_FULL;
        for (i = 0; i < TASK_SLOTS; i++) begin
          if (!task_used[i] && r.status == STAT_FULL) begin
            task_used[i]       = 1'b1;
            task_start_hms[i]  = {c.start_h, c.start_m, c.start_s};
            task_stop_hms[i]   = {c.stop_h, c.stop_m, c.stop_s};
            task_active_hms[i] = {default_hour, default_minute, default_second};
            task_start_secs[i] = hms_to_seconds(task_start_hms[i]);
            task_stop_secs[i]  = hms_to_seconds(task_stop_hms[i]);
            task_features[i]   = c.flags;
            task_program[i]    = c.value;
            r.status           = STAT_OK;
            r.assigned         = SLOT_W'(i + 1);
          end
        end
      end
    end else if (c.cmd == CMD_SEARCH) begin
      for (i = 0; i < TASK_SLOTS; i++) begin
        if (!r.found && task_used[i] && c.now > task_start_secs[i] &&
            c.now < task_stop_secs[i]) begin
          r.found = 1'b1;
          r.index = MATCH_W'(i);
        end
      end
    end else if (c.slot == 0 || c.slot > TASK_SLOTS || !task_used[c.slot - 1]) begin
      r.status = STAT_NO_ENTRY;
    end else if (c.cmd == CMD_REMOVE) begin
      // channels survive and pass on to the next add here; that add rewrites the program
      task_used[c.slot - 1]     = 1'b0;
      task_features[c.slot - 1] = '0;
    end else begin
      idx = c.slot - 1;
      if (c.prm <= PRM_ACT_S) begin
        part  = hms_part_e'(c.prm % 3);
        limit = (part == PART_HOUR) ? HOUR_LIMIT : MINSEC_LIMIT;
        if (c.value > limit) begin
          r.status = STAT_BAD;
        end else if (c.prm < PRM_STOP_H) begin
          task_start_hms[idx] = hms_splice(task_start_hms[idx], part, c.value);
        end else if (c.prm < PRM_ACT_H) begin
          task_stop_hms[idx] = hms_splice(task_stop_hms[idx], part, c.value);
        end else begin
          task_active_hms[idx] = hms_splice(task_active_hms[idx], part, c.value);
        end
      end else if (c.prm <= PRM_ACTUATE) begin
        task_features[idx][c.prm - PRM_MOTION] = (c.value != 0);
      end else if (c.prm == PRM_CHANNEL) begin
        if (c.value == 0 || c.value > CHANNEL_COUNT) r.status = STAT_BAD;
        else task_channels[idx][c.value - 1] = ~task_channels[idx][c.value - 1];
      end else if (c.prm == PRM_PROGRAM) begin
        task_program[idx] = c.value;
      end else begin
        r.status = STAT_BAD;
      end
      task_start_secs[idx] = hms_to_seconds(task_start_hms[idx]);
      task_stop_secs[idx]  = hms_to_seconds(task_stop_hms[idx]);
    end
    return r;
  endfunction

  function automatic command_t add_command(input logic [HOUR_W-1:0] sh,
                                           input logic [MIN_W-1:0] sm, input logic [SEC_W-1:0] ss,
                                           input logic [HOUR_W-1:0] eh,
                                           input logic [MIN_W-1:0] em, input logic [SEC_W-1:0] es,
                                           input logic [VALUE_W-1:0] prog,
                                           input logic [FEAT_W-1:0] flags);
    command_t c;
    c = '0;
    c.cmd = CMD_ADD;
    {c.start_h, c.start_m, c.start_s} = {sh, sm, ss};
    {c.stop_h, c.stop_m, c.stop_s} = {eh, em, es};
    c.value = prog;
    c.flags = flags;
    return c;
  endfunction

  function automatic command_t slot_command(input cmd_e op, input logic [SLOT_W-1:0] slot,
                                            input logic [PARAM_W-1:0] prm,
                                            input logic [VALUE_W-1:0] value);
    command_t c;
    c = '0;
    c.cmd   = op;
    c.slot  = slot;
    c.prm   = prm;
    c.value = value;
    return c;
  endfunction

  function automatic command_t search_command(input logic [NOW_W-1:0] now);
    command_t c;
    c = '0;
    c.cmd = CMD_SEARCH;
    c.now = now;
    return c;
  endfunction

  // mostly well-formed commands aimed at the current table, some noise
  function automatic command_t random_command(input int mix);
    command_t    c;
    logic [95:0] noise;
    hms_t        a, b, t;
    int          used_pool[$];
    int          window_pool[$];
    int          add_pct, remove_pct, set_pct;
    int          i, roll, pick;
    case (mix)
      0:       begin add_pct = 30; remove_pct = 20; set_pct = 25; end
      1:       begin add_pct = 55; remove_pct = 5;  set_pct = 15; end
      2:       begin add_pct = 10; remove_pct = 45; set_pct = 20; end
      default: begin add_pct = 20; remove_pct = 10; set_pct = 15; end
    endcase
    for (i = 0; i < TASK_SLOTS; i++) begin
      if (task_used[i]) begin
        used_pool.push_back(i);
        if (task_stop_secs[i] > task_start_secs[i] + 1) window_pool.push_back(i);
      end
    end
    noise = {$urandom, $urandom, $urandom};
    c = noise[$bits(command_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < add_pct) c.cmd = CMD_ADD;
    else if (roll < add_pct + remove_pct) c.cmd = CMD_REMOVE;
    else if (roll < add_pct + remove_pct + set_pct) c.cmd = CMD_SET;
    else c.cmd = CMD_SEARCH;

    if (c.cmd == CMD_ADD) begin
      a = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59))};
      b = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59))};
      if (hms_to_seconds(a) > hms_to_seconds(b) && $urandom_range(0, 3) != 0) begin
        t = a;
        a = b;
        b = t;
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       a = hms_t'($urandom);
          1:       b = hms_t'($urandom);
          default: begin a = hms_t'($urandom); b = hms_t'($urandom); end
        endcase
      end
      {c.start_h, c.start_m, c.start_s} = a;
      {c.stop_h, c.stop_m, c.stop_s} = b;
    end else if (c.cmd == CMD_SEARCH) begin
      roll = $urandom_range(0, 9);
      if (roll < 6 && window_pool.size() != 0) begin
        pick  = window_pool[$urandom_range(0, window_pool.size() - 1)];
        c.now = NOW_W'($urandom_range(task_start_secs[pick] + 1, task_stop_secs[pick] - 1));
      end else if (roll < 7 && used_pool.size() != 0) begin
        pick  = used_pool[$urandom_range(0, used_pool.size() - 1)];
        c.now = $urandom_range(0, 1) ? task_start_secs[pick] : task_stop_secs[pick];
      end else if (roll < 9) begin
        c.now = NOW_W'($urandom_range(0, 86399));
      end
      // otherwise the noise value stands, often past the end of the day
    end else begin
      if (used_pool.size() != 0 && $urandom_range(0, 6) != 0)
        c.slot = SLOT_W'(used_pool[$urandom_range(0, used_pool.size() - 1)] + 1);
      if (c.cmd == CMD_SET) begin
        if ($urandom_range(0, 19) == 0) c.prm = $urandom_range(0, 1) ? PRM_SPARE_LO : PRM_SPARE_HI;
        else c.prm = PARAM_W'($urandom_range(0, 13));
        if (c.prm <= PRM_ACT_S && $urandom_range(0, 6) != 0)
          c.value = (c.prm % 3 == 0) ? VALUE_W'($urandom_range(0, HOUR_LIMIT))
                                     : VALUE_W'($urandom_range(0, MINSEC_LIMIT));
        else if (c.prm == PRM_CHANNEL && $urandom_range(0, 4) != 0)
          c.value = VALUE_W'($urandom_range(1, CHANNEL_COUNT));
        else if (c.prm >= PRM_MOTION && c.prm <= PRM_ACTUATE && $urandom_range(0, 1) == 0)
          c.value = '0;
      end
    end
    return c;
  endfunction

  task automatic send_command(input command_t c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    cmd_i           <= c.cmd;
    slot_i          <= c.slot;
    param_i         <= c.prm;
    value_i         <= c.value;
    start_hour_i    <= c.start_h;
    start_minute_i  <= c.start_m;
    start_second_i  <= c.start_s;
    stop_hour_i     <= c.stop_h;
    stop_minute_i   <= c.stop_m;
    stop_second_i   <= c.stop_s;
    feature_flags_i <= c.flags;
    now_seconds_i   <= c.now;
    // stall is settled at the falling edge, the item goes in at the next rise
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    expected_results.push_back(predict_command(c));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_active_default(input logic [CFG_DATA_W-1:0] h,
                                     input logic [CFG_DATA_W-1:0] m,
                                     input logic [CFG_DATA_W-1:0] s);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ACT_HOUR;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACT_MIN;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACT_SEC;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    default_hour   = h[HOUR_W-1:0];
    default_minute = m[MIN_W-1:0];
    default_second = s[SEC_W-1:0];
  endtask

  task automatic test_add_checks();
    load_active_default(23, 59, 59);
    send_command(add_command(0, 0, 0, 23, 59, 59, 255, 7));
    send_command(add_command(23, 59, 59, 0, 0, 0, 0, 0));
    send_command(add_command(24, 0, 0, 1, 0, 0, 1, 1));
    send_command(add_command(1, 0, 0, 2, 60, 0, 2, 2));
    send_command(add_command(1, 0, 63, 31, 0, 0, 3, 4));
  endtask

  task automatic test_search_bounds();
    send_command(search_command(0));
    send_command(search_command(1));
    send_command(search_command(86398));
    send_command(search_command(86399));
    send_command(search_command('1));
  endtask

  task automatic test_slot_checks();
    send_command(slot_command(CMD_SET, 0, PRM_PROGRAM, 1));
    send_command(slot_command(CMD_REMOVE, 17, PRM_START_H, 0));
    send_command(slot_command(CMD_REMOVE, 31, PRM_START_H, 0));
    send_command(slot_command(CMD_SET, 3, PRM_PROGRAM, 1));
    send_command(slot_command(CMD_REMOVE, 2, PRM_START_H, 0));
    send_command(slot_command(CMD_REMOVE, 2, PRM_START_H, 0));
  endtask

  task automatic test_set_fields();
    send_command(slot_command(CMD_SET, 1, PRM_START_H, 24));
    send_command(slot_command(CMD_SET, 1, PRM_START_H, 12));
    send_command(slot_command(CMD_SET, 1, PRM_STOP_M, 60));
    send_command(slot_command(CMD_SET, 1, PRM_ACT_S, 59));
    send_command(slot_command(CMD_SET, 1, PRM_MOTION, 0));
    send_command(slot_command(CMD_SET, 1, PRM_AUDIO, 200));
    send_command(slot_command(CMD_SET, 1, PRM_ACTUATE, 1));
    send_command(slot_command(CMD_SET, 1, PRM_CHANNEL, 0));
    send_command(slot_command(CMD_SET, 1, PRM_CHANNEL, CHANNEL_COUNT + 1));
    send_command(slot_command(CMD_SET, 1, PRM_CHANNEL, CHANNEL_COUNT));
    send_command(slot_command(CMD_SET, 1, PRM_PROGRAM, 77));
    send_command(slot_command(CMD_SET, 1, PRM_SPARE_LO, 5));
    send_command(slot_command(CMD_SET, 1, PRM_SPARE_HI, 5));
    // start is now 12:00:00, so the window opens one second later
    send_command(search_command(43200));
    send_command(search_command(43201));
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       load_active_default('1, '1, '1);
        1:       load_active_default(0, 0, 0);
        default: load_active_default(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                     CFG_DATA_W'($urandom));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_command(random_command(phase % 4));
    end
  endtask

  function automatic void check_field(input string field, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endfunction

  // a result is taken at the rising edge after a falling edge that shows it unstalled
  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none pending: status %0d slot %0d found %0d index %0d",
                 $time, status_o, assigned_slot_o, match_found_o, match_index_o);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 17'(want.status), 17'(status_o));
        check_field("assigned_slot", 17'(want.assigned), 17'(assigned_slot_o));
        check_field("match_found", 17'(want.found), 17'(match_found_o));
        check_field("match_index", 17'(want.index), 17'(match_index_o));
      end
    end
  end

  // receiver stalls in runs of random length and density
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stall_run == 0) begin
      stall_run <= $urandom_range(1, 32);
      case ($urandom_range(0, 4))
        0, 1:    stall_pct <= 0;
        2:       stall_pct <= 25;
        3:       stall_pct <= 60;
        default: stall_pct <= 100;
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_checks();
    test_search_bounds();
    test_slot_checks();
    test_set_fields();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/twt_pkg.sv
design/twt_alu.sv
design/twt_table.sv
design/time_window_task_table.sv
tb/sv/time_window_task_table_test.sv
